>>> hw/rtl/dsw_pkg.sv
// ----------------------------------------------------------------------------
// dsw_pkg: shared types, constants and arithmetic helpers
// Action codes, time-span and result structures, and the constant dividers
// used to split an elapsed tick count into display units.
// ----------------------------------------------------------------------------
package dsw_pkg;

    localparam int unsigned STAMP_WIDTH_DEF = 48;

    localparam int unsigned ELAPSED_W  = 34;
    localparam int unsigned TICK_SHIFT = 10;
    localparam int unsigned SEC_W      = 24;
    localparam int unsigned MIN_W      = 18;
    localparam int unsigned HR_W       = 12;
    localparam int unsigned PAIR_W     = 7;

    // 99 days 23:59:59.99 expressed in ticks.
    localparam logic [ELAPSED_W-1:0] CAP_TICKS = 34'd8847359999;

    // ceil(2^30 / 60) and ceil(2^16 / 24); exact over the capped ranges.
    localparam logic [24:0] RECIP_60 = 25'd17895698;
    localparam logic [11:0] RECIP_24 = 12'd2731;

    typedef enum logic [2:0] {
        ACT_REFRESH  = 3'd0,
        ACT_TOGGLE_A = 3'd1,
        ACT_TOGGLE_B = 3'd2,
        ACT_SWAP     = 3'd3,
        ACT_ACTIVATE = 3'd4
    } t_action;

    typedef struct packed {
        logic [6:0] days;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [6:0] centis;
    } t_span;

    typedef struct packed {
        logic sel;
        logic run_sel;
        logic run_oth;
        logic run_a;
        logic run_b;
        logic blink_phase;
    } t_flags;

    typedef struct packed {
        logic              shown_timer;
        logic [PAIR_W-1:0] pair_high;
        logic [PAIR_W-1:0] pair_middle;
        logic [PAIR_W-1:0] pair_low;
        logic              colon_on;
        logic              other_blink;
        logic              other_active;
        logic [PAIR_W-1:0] other_value;
        logic              running_a;
        logic              running_b;
    } t_result;

    // Quotient by 60 through a reciprocal multiply.
    function automatic logic [MIN_W-1:0] div60(input logic [SEC_W-1:0] x);
        logic [47:0] prod;
        prod = {24'd0, x} * {23'd0, RECIP_60};
        return prod[47:30];
    endfunction

    // Remainder by 60 given the quotient; q*60 is formed as q*64 - q*4.
    function automatic logic [5:0] rem60(input logic [SEC_W-1:0] x,
                                         input logic [MIN_W-1:0] q);
        logic [SEC_W-1:0] q60;
        logic [SEC_W-1:0] diff;
        q60  = {q, 6'b0} - {4'b0, q, 2'b0};
        diff = x - q60;
        return diff[5:0];
    endfunction

    function automatic logic [6:0] div24(input logic [HR_W-1:0] x);
        logic [23:0] prod;
        prod = {12'd0, x} * {12'd0, RECIP_24};
        return prod[22:16];
    endfunction

    function automatic logic [4:0] rem24(input logic [HR_W-1:0] x,
                                         input logic [6:0] q);
        logic [HR_W-1:0] q24;
        logic [HR_W-1:0] diff;
        q24  = {1'b0, q, 4'b0} + {2'b0, q, 3'b0};
        diff = x - q24;
        return diff[4:0];
    endfunction

    // Centiseconds from a 10-bit tick fraction: (frac * 100) >> 10.
    function automatic logic [6:0] frac_to_centis(input logic [TICK_SHIFT-1:0] frac);
        logic [16:0] prod;
        prod = {1'b0, frac, 6'b0} + {2'b0, frac, 5'b0} + {5'b0, frac, 2'b0};
        return prod[16:10];
    endfunction

endpackage

>>> hw/rtl/dsw_timers.sv
// ----------------------------------------------------------------------------
// dsw_timers: timer state and elapsed time
// Holds the start stamps, held elapsed counts, run flags and shown-timer
// select; applies one action per beat and gives the saturated elapsed time
// of the shown and the other timer as seen after that action.
// ----------------------------------------------------------------------------
module dsw_timers import dsw_pkg::*; #(
    parameter int unsigned STAMP_WIDTH = STAMP_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [2:0]             i_action,
    input  logic [STAMP_WIDTH-1:0] i_now,
    output t_flags                 o_flags,
    output logic [ELAPSED_W-1:0]   o_elapsed_sel,
    output logic [ELAPSED_W-1:0]   o_elapsed_oth
);

    logic [STAMP_WIDTH-1:0] r_start [2];
    logic [STAMP_WIDTH-1:0] n_start [2];
    logic [ELAPSED_W-1:0]   r_held  [2];
    logic [ELAPSED_W-1:0]   n_held  [2];
    logic [ELAPSED_W-1:0]   elapsed [2];
    logic [1:0]             r_run;
    logic [1:0]             n_run;
    logic                   r_sel;
    logic                   n_sel;
    logic [1:0]             toggle;
    logic                   swap;
    logic                   activate;

    // A difference that does not fit the display range saturates at the cap.
    function automatic logic [ELAPSED_W-1:0] sat_diff(input logic [STAMP_WIDTH-1:0] d);
        if ((|d[STAMP_WIDTH-1:ELAPSED_W]) || (d[ELAPSED_W-1:0] > CAP_TICKS)) begin
            return CAP_TICKS;
        end
        return d[ELAPSED_W-1:0];
    endfunction

    always_comb begin
        toggle   = 2'b00;
        swap     = 1'b0;
        activate = 1'b0;
        case (t_action'(i_action))
            ACT_TOGGLE_A: toggle[0] = i_fire;
            ACT_TOGGLE_B: toggle[1] = i_fire;
            ACT_SWAP:     swap      = i_fire;
            ACT_ACTIVATE: activate  = i_fire;
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_start[i] = r_start[i];
            n_held[i]  = r_held[i];
            n_run[i]   = r_run[i];
            if (toggle[i]) begin
                if (r_run[i]) begin
                    n_held[i] = sat_diff(i_now - r_start[i]);
                    n_run[i]  = 1'b0;
                end else begin
                    n_start[i] = i_now;
                    n_run[i]   = 1'b1;
                end
            end
            elapsed[i] = n_run[i] ? sat_diff(i_now - n_start[i]) : n_held[i];
        end

        n_sel = r_sel;
        if (swap) begin
            n_sel = ~r_sel;
        end else if (activate && (|r_run)) begin
            n_sel = ~r_run[0];
        end
    end

    always_comb begin
        o_elapsed_sel       = n_sel ? elapsed[1] : elapsed[0];
        o_elapsed_oth       = n_sel ? elapsed[0] : elapsed[1];
        o_flags.sel         = n_sel;
        o_flags.run_sel     = n_sel ? n_run[1] : n_run[0];
        o_flags.run_oth     = n_sel ? n_run[0] : n_run[1];
        o_flags.run_a       = n_run[0];
        o_flags.run_b       = n_run[1];
        o_flags.blink_phase = ~i_now[TICK_SHIFT-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_start[i] <= '0;
                r_held[i]  <= '0;
            end
            r_run <= 2'b00;
            r_sel <= 1'b0;
        end else if (i_fire) begin
            for (int i = 0; i < 2; i++) begin
                r_start[i] <= n_start[i];
                r_held[i]  <= n_held[i];
            end
            r_run <= n_run;
            r_sel <= n_sel;
        end
    end

endmodule

>>> hw/rtl/dsw_split.sv
// ----------------------------------------------------------------------------
// dsw_split: elapsed ticks to days, hours, minutes, seconds, centiseconds
// Two register stages, one constant divide each, then the day/hour split
// in front of the result register.
// ----------------------------------------------------------------------------
module dsw_split import dsw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_ld_mid,
    input  logic                 i_ld_low,
    input  logic [ELAPSED_W-1:0] i_elapsed,
    output t_span                o_span
);

    logic [SEC_W-1:0] secs_total;
    logic [MIN_W-1:0] n_min_total;
    logic [MIN_W-1:0] r_min_total;
    logic [5:0]       r_sec_mid;
    logic [6:0]       r_centi_mid;
    logic [MIN_W-1:0] hr_quot;
    logic [HR_W-1:0]  r_hr_total;
    logic [5:0]       r_min_low;
    logic [5:0]       r_sec_low;
    logic [6:0]       r_centi_low;
    logic [6:0]       days;

    assign secs_total  = i_elapsed[TICK_SHIFT +: SEC_W];
    assign n_min_total = div60(secs_total);

    always_ff @(posedge i_clk) begin
        if (i_ld_mid) begin
            r_min_total <= n_min_total;
            r_sec_mid   <= rem60(secs_total, n_min_total);
            r_centi_mid <= frac_to_centis(i_elapsed[TICK_SHIFT-1:0]);
        end
    end

    assign hr_quot = div60({{(SEC_W-MIN_W){1'b0}}, r_min_total});

    always_ff @(posedge i_clk) begin
        if (i_ld_low) begin
            r_hr_total  <= hr_quot[HR_W-1:0];
            r_min_low   <= rem60({{(SEC_W-MIN_W){1'b0}}, r_min_total}, hr_quot);
            r_sec_low   <= r_sec_mid;
            r_centi_low <= r_centi_mid;
        end
    end

    // The cap keeps the day count below 100, so no modulo is needed there.
    assign days = div24(r_hr_total);

    always_comb begin
        o_span.days    = days;
        o_span.hours   = rem24(r_hr_total, days);
        o_span.minutes = r_min_low;
        o_span.seconds = r_sec_low;
        o_span.centis  = r_centi_low;
    end

endmodule

>>> hw/rtl/dsw_format.sv
// ----------------------------------------------------------------------------
// dsw_format: display field selection
// Picks the three digit pairs of the shown timer, the colon state and the
// summary of the other timer from the split spans and the run flags.
// ----------------------------------------------------------------------------
module dsw_format import dsw_pkg::*; (
    input  t_span   i_cur,
    input  t_span   i_oth,
    input  t_flags  i_flags,
    output t_result o_result
);

    logic [PAIR_W-1:0] oth_value;

    always_comb begin
        if (i_cur.days != '0) begin
            o_result.pair_high   = i_cur.days;
            o_result.pair_middle = PAIR_W'(i_cur.hours);
            o_result.pair_low    = PAIR_W'(i_cur.minutes);
        end else if (i_cur.hours != '0) begin
            o_result.pair_high   = PAIR_W'(i_cur.hours);
            o_result.pair_middle = PAIR_W'(i_cur.minutes);
            o_result.pair_low    = PAIR_W'(i_cur.seconds);
        end else begin
            o_result.pair_high   = PAIR_W'(i_cur.minutes);
            o_result.pair_middle = PAIR_W'(i_cur.seconds);
            o_result.pair_low    = i_cur.centis;
        end

        if (i_oth.days != '0) begin
            oth_value = i_oth.days;
        end else if (i_oth.hours != '0) begin
            oth_value = PAIR_W'(i_oth.hours);
        end else if (i_oth.minutes != '0) begin
            oth_value = PAIR_W'(i_oth.minutes);
        end else if (i_oth.seconds != '0) begin
            oth_value = PAIR_W'(i_oth.seconds);
        end else begin
            oth_value = i_oth.centis;
        end

        o_result.shown_timer  = i_flags.sel;
        o_result.colon_on     = (i_cur.centis > 7'd50) || !i_flags.run_sel;
        o_result.other_blink  = i_flags.run_oth && i_flags.blink_phase;
        o_result.other_active = i_flags.run_oth;
        o_result.other_value  = i_flags.run_oth ? oth_value : '0;
        o_result.running_a    = i_flags.run_a;
        o_result.running_b    = i_flags.run_b;
    end

endmodule

>>> hw/rtl/dual_stopwatch_display_top.sv
// ----------------------------------------------------------------------------
// dual_stopwatch_display_top: two-timer stopwatch display
// Each input beat carries an action and a 1/1024 s timestamp and yields one
// result beat. The block is a five-register pipeline (input register, timer
// update, two constant-divide stages, result register) that each beat passes
// through in order; one beat can be taken every cycle unless a waiting result
// has backed the stalls up into the input register. The timer state is updated
// as a beat leaves the input register, so back-to-back actions see each other
// in order. Each stage moves on as soon as the stage after it is empty or
// moving; a waiting result stalls only the stages behind it that are full.
// ----------------------------------------------------------------------------
module dual_stopwatch_display_top import dsw_pkg::*; #(
    parameter int unsigned STAMP_WIDTH = STAMP_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_action,
    input  logic [STAMP_WIDTH-1:0] i_now_ticks,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_shown_timer,
    output logic [PAIR_W-1:0]      o_pair_high,
    output logic [PAIR_W-1:0]      o_pair_middle,
    output logic [PAIR_W-1:0]      o_pair_low,
    output logic                   o_colon_on,
    output logic                   o_other_blink,
    output logic                   o_other_active,
    output logic [PAIR_W-1:0]      o_other_value,
    output logic                   o_running_a,
    output logic                   o_running_b
);

    localparam int unsigned NUM_STAGES = 5;

    logic [NUM_STAGES-1:0]  r_valid;
    logic [NUM_STAGES-1:0]  stage_rdy;
    logic [NUM_STAGES-1:0]  stage_ld;

    logic [2:0]             r_action;
    logic [STAMP_WIDTH-1:0] r_now;

    t_flags                 upd_flags;
    logic [ELAPSED_W-1:0]   upd_el_sel;
    logic [ELAPSED_W-1:0]   upd_el_oth;

    t_flags                 r_flags1;
    t_flags                 r_flags2;
    t_flags                 r_flags3;
    logic [ELAPSED_W-1:0]   r_el_sel;
    logic [ELAPSED_W-1:0]   r_el_oth;

    t_span                  span_cur;
    t_span                  span_oth;
    t_result                fmt_result;
    t_result                r_result;

    always_comb begin
        stage_rdy[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_valid[k] || stage_rdy[k+1];
        end
        stage_ld[0] = stage_rdy[0] && i_in_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            stage_ld[k] = stage_rdy[k] && r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ld[0]) begin
            r_action <= i_action;
            r_now    <= i_now_ticks;
        end
    end

    dsw_timers #(
        .STAMP_WIDTH(STAMP_WIDTH)
    ) u_timers (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (stage_ld[1]),
        .i_action      (r_action),
        .i_now         (r_now),
        .o_flags       (upd_flags),
        .o_elapsed_sel (upd_el_sel),
        .o_elapsed_oth (upd_el_oth)
    );

    always_ff @(posedge i_clk) begin
        if (stage_ld[1]) begin
            r_flags1 <= upd_flags;
            r_el_sel <= upd_el_sel;
            r_el_oth <= upd_el_oth;
        end
        if (stage_ld[2]) begin
            r_flags2 <= r_flags1;
        end
        if (stage_ld[3]) begin
            r_flags3 <= r_flags2;
        end
        if (stage_ld[4]) begin
            r_result <= fmt_result;
        end
    end

    dsw_split u_split_cur (
        .i_clk     (i_clk),
        .i_ld_mid  (stage_ld[2]),
        .i_ld_low  (stage_ld[3]),
        .i_elapsed (r_el_sel),
        .o_span    (span_cur)
    );

    dsw_split u_split_oth (
        .i_clk     (i_clk),
        .i_ld_mid  (stage_ld[2]),
        .i_ld_low  (stage_ld[3]),
        .i_elapsed (r_el_oth),
        .o_span    (span_oth)
    );

    dsw_format u_format (
        .i_cur    (span_cur),
        .i_oth    (span_oth),
        .i_flags  (r_flags3),
        .o_result (fmt_result)
    );

    assign o_in_ready     = stage_rdy[0];
    assign o_out_valid    = r_valid[NUM_STAGES-1];
    assign o_shown_timer  = r_result.shown_timer;
    assign o_pair_high    = r_result.pair_high;
    assign o_pair_middle  = r_result.pair_middle;
    assign o_pair_low     = r_result.pair_low;
    assign o_colon_on     = r_result.colon_on;
    assign o_other_blink  = r_result.other_blink;
    assign o_other_active = r_result.other_active;
    assign o_other_value  = r_result.other_value;
    assign o_running_a    = r_result.running_a;
    assign o_running_b    = r_result.running_b;

    // A result never shows up right after reset without an input beat.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid directly after reset");

    // All digit pairs come out of the capped split and stay decimal.
    a_pairs_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pair_high <= 7'd99) && (o_pair_middle <= 7'd99)
                        && (o_pair_low <= 7'd99) && (o_other_value <= 7'd99))
        else $error("digit pair out of range");

    // The other-timer summary is blank unless that timer runs.
    a_other_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_other_active) |-> (o_other_value == '0) && !o_other_blink)
        else $error("other timer summary shown while it is stopped");

    // A stopped shown timer always has its colon lit.
    a_colon_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !(o_shown_timer ? o_running_b : o_running_a)) |-> o_colon_on)
        else $error("colon dark on a stopped shown timer");

endmodule
